### rtl/sha1_counter_keystream_cipher_defines.svh
// Assertion macros for the checker of the keystream cipher.
// Depends on nothing; included by the checker module.
`ifndef SHA1_COUNTER_KEYSTREAM_CIPHER_DEFINES_SVH
`define SHA1_COUNTER_KEYSTREAM_CIPHER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SKC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### rtl/skc_pkg.sv
// Package of the SHA-1 counter keystream cipher: widths, constants,
// register indexes, controller state type and SHA-1 helper functions.
package skc_pkg;
    localparam int unsigned BlockBytes = 16;
    localparam int unsigned CfgIdxW    = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_HIGH      = 2'd0,
        REG_KEY_LOW       = 2'd1,
        REG_COUNTER_START = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD1,
        ST_ROUND,
        ST_FOLD,
        ST_LOAD2,
        ST_FINAL,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;     // latch input beat
        logic load_blk1;   // load context block and initial hash
        logic load_blk2;   // load padding block
        logic round;       // run one SHA-1 round
        logic fold;        // add working vars into hash
        logic keep_ks;     // store digest as keystream
        logic emit;        // form output byte and advance position
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_ks;     // block start: keystream must be computed
        logic last_round;  // round counter at 79
    } t_stat;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] round_k(input logic [6:0] i);
        logic [31:0] k;
        if (i < 7'd20)      k = 32'h5A827999;
        else if (i < 7'd40) k = 32'h6ED9EBA1;
        else if (i < 7'd60) k = 32'h8F1BBCDC;
        else                k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] i,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (i < 7'd20)      f = (b & c) | (~b & d);
        else if (i < 7'd40) f = b ^ c ^ d;
        else if (i < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction
endpackage

### rtl/skc_if.sv
// Valid/ready channel interfaces for data beats and configuration writes.
// Depends on skc_pkg.
interface skc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       restart;
    logic       last_byte;
    modport source (output valid, data_in, restart, last_byte, input ready);
    modport sink   (input valid, data_in, restart, last_byte, output ready);
endinterface

interface skc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    modport source (output valid, data_out, input ready);
    modport sink   (input valid, data_out, output ready);
endinterface

interface skc_cfg_if;
    import skc_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sha1_counter_keystream_cipher.sv
// Top level of the SHA-1 counter-mode keystream cipher.
// Depends on skc_pkg, skc_if, skc_ctrl and skc_dp.
//
// Each byte beat on the input channel is XORed with one keystream byte and
// leaves as one beat on the output channel. At the first byte of a block
// (position zero, or after a restart) the keystream is made by one SHA-1
// round engine running one round per cycle over two compression blocks, so
// that byte waits on the single round unit and its 80-round loop. The other
// fifteen bytes of a block reuse the stored keystream. The output register
// holds one result; a new byte is taken while it waits, and the block
// waits only if a second result would overwrite it. Configuration writes
// are always accepted and should be made only while the block is idle.
module sha1_counter_keystream_cipher (
    input  logic  i_clk,
    input  logic  i_rst_n,
    skc_in_if.sink    in_ch,
    skc_out_if.source out_ch,
    skc_cfg_if.sink   cfg_ch
);
    import skc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign cfg_ch.ready = 1'b1;

    skc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_out_busy (out_ch.valid && !out_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ch.ready)
    );

    skc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (cfg_ch.valid),
        .i_cfg_idx   (cfg_ch.index),
        .i_cfg_data  (cfg_ch.data),
        .i_data_in   (in_ch.data_in),
        .i_restart   (in_ch.restart),
        .i_last_byte (in_ch.last_byte),
        .i_out_ready (out_ch.ready),
        .o_stat      (stat),
        .o_out_valid (out_ch.valid),
        .o_data_out  (out_ch.data_out)
    );
endmodule

### rtl/skc_ctrl.sv
// Controller state machine of the keystream cipher.
// Depends on skc_pkg; drives commands into skc_dp.
module skc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_busy,
    input  skc_pkg::t_stat i_stat,
    output skc_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);
    import skc_pkg::*;

    t_state r_state, n_state;
    logic   r_second;
    logic   n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_LOAD1;
            ST_LOAD1: begin
                if (i_stat.need_ks) begin
                    n_state  = ST_ROUND;
                    n_second = 1'b0;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_ROUND: if (i_stat.last_round) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_second ? ST_FINAL : ST_LOAD2;
            ST_LOAD2: begin
                n_state  = ST_ROUND;
                n_second = 1'b1;
            end
            ST_FINAL: n_state = ST_OUT;
            ST_OUT:   if (!i_out_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE:  begin
                o_in_ready   = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            ST_LOAD1: o_cmd.load_blk1 = i_stat.need_ks;
            ST_ROUND: o_cmd.round = 1'b1;
            ST_FOLD:  o_cmd.fold = 1'b1;
            ST_LOAD2: o_cmd.load_blk2 = 1'b1;
            ST_FINAL: o_cmd.keep_ks = 1'b1;
            ST_OUT:   o_cmd.emit = !i_out_busy;
            default:  o_cmd = '0;
        endcase
    end
endmodule

### rtl/skc_dp.sv
// Datapath: configuration registers, counter, SHA-1 round engine,
// keystream store and output register. Depends on skc_pkg.
module skc_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  skc_pkg::t_cmd           i_cmd,
    input  logic                    i_cfg_we,
    input  logic [skc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0]             i_cfg_data,
    input  logic [7:0]              i_data_in,
    input  logic                    i_restart,
    input  logic                    i_last_byte,
    input  logic                    i_out_ready,
    output skc_pkg::t_stat          o_stat,
    output logic                    o_out_valid,
    output logic [7:0]              o_data_out
);
    import skc_pkg::*;

    logic [63:0] r_key_high, r_key_low, r_ctr_start, r_ctr;
    logic [3:0]  r_pos;
    logic [7:0]  r_data;
    logic        r_last;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [6:0]  r_rnd;
    logic [7:0]  r_ks [BlockBytes];
    logic        r_out_valid;
    logic [7:0]  r_out;

    logic [31:0] w_cur, w_new, t_sum;
    logic [63:0] ctr_eff;
    logic [31:0] ctx [16];

    assign ctr_eff = r_ctr;
    assign w_cur   = r_w[0];
    assign w_new   = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1 |
                     {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} >> 31;
    assign t_sum   = {r_a[26:0], r_a[31:27]} + round_f(r_rnd, r_b, r_c, r_d) +
                     r_e + round_k(r_rnd) + w_cur;

    always_comb begin
        for (int i = 0; i < 16; i++) ctx[i] = '0;
        ctx[0]  = r_key_high[63:32];
        ctx[1]  = r_key_high[31:0];
        ctx[2]  = r_key_high[63:32];
        ctx[3]  = r_key_high[31:0];
        ctx[4]  = r_key_low[63:32];
        ctx[5]  = r_key_low[31:0];
        ctx[6]  = r_key_low[63:32];
        ctx[7]  = r_key_low[31:0];
        ctx[14] = ctr_eff[63:32];
        ctx[15] = ctr_eff[31:0];
    end

    assign o_stat.need_ks    = (r_pos == 4'd0);
    assign o_stat.last_round = (r_rnd == 7'd79);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_ctr_start <= '1;
            r_ctr       <= '1;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_rnd       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_KEY_HIGH:      r_key_high  <= i_cfg_data;
                    REG_KEY_LOW:       r_key_low   <= i_cfg_data;
                    REG_COUNTER_START: r_ctr_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!i_cmd.emit && r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.take_in) begin
                r_data <= i_data_in;
                r_last <= i_last_byte;
                if (i_restart) begin
                    r_ctr <= r_ctr_start;
                    r_pos <= '0;
                end
            end
            if (i_cmd.load_blk1) begin
                for (int i = 0; i < 16; i++) r_w[i] <= ctx[i];
                r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
                r_a <= H0; r_b <= H1; r_c <= H2; r_d <= H3; r_e <= H4;
                r_rnd <= '0;
            end
            if (i_cmd.load_blk2) begin
                // Padding block: leading one bit, zeros, then the 512-bit length.
                for (int i = 0; i < 16; i++)
                    r_w[i] <= (i == 0) ? 32'h80000000 :
                              ((i == 15) ? 32'h00000200 : 32'h00000000);
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
                r_rnd <= '0;
            end
            if (i_cmd.round) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_a <= t_sum;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                r_rnd <= r_rnd + 7'd1;
            end
            if (i_cmd.fold) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.keep_ks) begin
                for (int i = 0; i < BlockBytes; i++)
                    r_ks[i] <= r_h[i/4][(3 - i%4)*8 +: 8];
            end
            if (i_cmd.emit) begin
                r_out       <= r_data ^ r_ks[r_pos];
                r_out_valid <= 1'b1;
                if (r_pos == 4'(BlockBytes - 1) || r_last) begin
                    r_ctr <= r_ctr + 64'd1;
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out;
endmodule

### rtl/skc_checker.sv
// Port-level checker for the keystream cipher, bound to the top level.
// Depends on the defines header.
`include "sha1_counter_keystream_cipher_defines.svh"
module skc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    // An accepted byte never leaves the input side ready in the next cycle.
    `SKC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // A result that waits stays offered.
    `SKC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // A fresh result is formed while the input side is closed.
    `SKC_ASSERT_IMPL(a_rise_after_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))
endmodule

bind sha1_counter_keystream_cipher skc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready)
);

### sim/tb_sha1_counter_keystream_cipher.sv
// Testbench for the SHA-1 counter-mode keystream cipher.
// Depends on skc_pkg, the skc_if channel interfaces and the cipher top level.
// It predicts every output byte with its own SHA-1 keystream model.
module tb_sha1_counter_keystream_cipher;
    import skc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       last;
    } t_beat;

    typedef struct packed {
        t_reg_idx    idx;
        logic [63:0] value;
    } t_cfg_write;

    logic i_clk;
    logic i_rst_n;

    skc_in_if  in_ch ();
    skc_out_if out_ch ();
    skc_cfg_if cfg_ch ();

    sha1_counter_keystream_cipher u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state, kept in step with the block as beats are accepted.
    logic [63:0] mdl_key_high;
    logic [63:0] mdl_key_low;
    logic [63:0] mdl_ctr_start;
    logic [63:0] mdl_block_ctr;
    logic [4:0]  mdl_pos;
    logic [7:0]  mdl_ks [16];

    t_beat       beat_q [$];
    t_cfg_write  cfg_q [$];
    logic [7:0]  expected_bytes [$];
    int          mismatch_cnt;
    bit          stim_done;
    bit          hold_sender;
    int          in_gap;
    int          out_gap;

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One SHA-1 compression of a 512-bit block into the hash words.
    task automatic sha1_compress(inout logic [31:0] h [5], input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endtask

    // Keystream of one block: the first 16 digest bytes of the 64-byte context.
    task automatic refresh_keystream();
        logic [31:0]  h [5];
        logic [511:0] ctx;
        logic [511:0] pad;
        h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
        h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
        ctx = {mdl_key_high, mdl_key_high, mdl_key_low, mdl_key_low, 192'd0, mdl_block_ctr};
        pad = {8'h80, 440'd0, 64'd512};
        sha1_compress(h, ctx);
        sha1_compress(h, pad);
        for (int i = 0; i < 16; i++) mdl_ks[i] = h[i/4][31 - 8*(i%4) -: 8];
    endtask

    // Works out the output byte for one accepted input beat.
    task automatic predict_cipher_byte(input t_beat bt);
        if (bt.restart) begin
            mdl_block_ctr = mdl_ctr_start;
            mdl_pos = 0;
        end
        if (mdl_pos == 0) refresh_keystream();
        expected_bytes.push_back(bt.data ^ mdl_ks[mdl_pos[3:0]]);
        mdl_pos = mdl_pos + 1;
        if (mdl_pos >= 16 || bt.last) begin
            mdl_block_ctr = mdl_block_ctr + 1;
            mdl_pos = 0;
        end
    endtask

    task automatic apply_cfg(input t_cfg_write wr);
        case (wr.idx)
            REG_KEY_HIGH:      mdl_key_high = wr.value;
            REG_KEY_LOW:       mdl_key_low = wr.value;
            REG_COUNTER_START: mdl_ctr_start = wr.value;
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 250);
        return $urandom_range(1, 3);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Input driver: one beat from the pending queue at a time, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_in <= '0;
            in_ch.restart <= 1'b0;
            in_ch.last_byte <= 1'b0;
            in_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_cipher_byte({in_ch.data_in, in_ch.restart, in_ch.last_byte});
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the beat until the block takes it.
            end else if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (beat_q.size() > 0 && !hold_sender) begin
                in_ch.valid <= 1'b1;
                {in_ch.data_in, in_ch.restart, in_ch.last_byte} <= beat_q.pop_front();
                in_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Configuration driver: writes come from the test sequence while idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_cfg({t_reg_idx'(cfg_ch.index), cfg_ch.data});
            end
            if (cfg_ch.valid && !cfg_ch.ready) begin
                // Wait for acceptance.
            end else if (cfg_q.size() > 0) begin
                cfg_ch.valid <= 1'b1;
                {cfg_ch.index, cfg_ch.data} <= cfg_q.pop_front();
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Output monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected output beat: data_out=%h", out_ch.data_out);
                end else begin
                    logic [7:0] exp_byte;
                    exp_byte = expected_bytes.pop_front();
                    if (exp_byte !== out_ch.data_out) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("data_out mismatch: expected %h got %h",
                                     exp_byte, out_ch.data_out);
                    end
                end
            end
            if (out_gap > 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid) out_gap <= pick_gap();
            end
        end
    end

    task automatic wait_drained();
        while (beat_q.size() > 0 || in_ch.valid || expected_bytes.size() > 0 ||
               cfg_q.size() > 0 || cfg_ch.valid)
            @(posedge i_clk);
        // The block may still be busy after its last result.
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        cfg_q.push_back({idx, value});
    endtask

    task automatic queue_beat(input logic [7:0] d, input bit rs, input bit lst);
        beat_q.push_back({d, rs, lst});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed calls: random-length runs of bytes, often opened by a restart.
    task automatic queue_random_calls(input int count);
        int n, len;
        n = 0;
        while (n < count) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len && n < count; i++, n++)
                queue_beat($urandom_range(0, 255),
                           (i == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 30) == 0,
                           i == len - 1 || $urandom_range(0, 40) == 0);
        end
    endtask

    initial begin
        mismatch_cnt = 0;
        stim_done = 0;
        hold_sender = 0;
        mdl_key_high = '0;
        mdl_key_low = '0;
        mdl_ctr_start = '1;
        mdl_block_ctr = '1;
        mdl_pos = 0;
        in_ch.valid = 1'b0;
        in_ch.data_in = '0;
        in_ch.restart = 1'b0;
        in_ch.last_byte = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: counter all ones wraps to zero after the first block.
        for (int i = 0; i < 18; i++) queue_beat(i == 0 ? 8'h00 : (i == 1 ? 8'hFF : 8'h5A), 0, 0);
        queue_beat(8'hA5, 1, 1);  // restart together with last byte
        queue_beat(8'h3C, 0, 1);  // single-byte call closes a partial block
        wait_drained();

        // Extreme settings, then a key change between calls.
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_COUNTER_START, 64'hFFFF_FFFF_FFFF_FFFE);
        wait_drained();
        queue_beat(8'h00, 1, 0);
        for (int i = 0; i < 20; i++) queue_beat($urandom_range(0, 255), 0, i == 19);
        wait_drained();
        write_reg(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_COUNTER_START, '0);
        wait_drained();
        // The new counter start only applies at the next restart.
        for (int i = 0; i < 5; i++) queue_beat(8'hFF, i == 3, 0);
        wait_drained();

        // Random phases with random settings.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_KEY_HIGH, rand64());
            write_reg(REG_KEY_LOW, ph == 4 ? 64'd0 : rand64());
            write_reg(REG_COUNTER_START, ph == 2 ? '1 : rand64());
            wait_drained();
            queue_random_calls(50);
            if (ph == 1) begin
                // Sender holds off until every pending result has come back.
                while (beat_q.size() > 0 || in_ch.valid) @(posedge i_clk);
                hold_sender = 1;
                while (expected_bytes.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            queue_random_calls(50);
            wait_drained();
        end

        if (mismatch_cnt == 0 && expected_bytes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
